/* src/pctm_pkg.sv */
package pctm_pkg;

	// Defaults for the top-level parameters.
	localparam int DEF_EXT_BYTES   = 4;
	localparam int DEF_QUEUE_DEPTH = 4;

	// Fixed widths of the datapath.
	localparam int CRC_W   = 32;
	localparam int ORD_W   = 16;
	localparam int CNT_W   = 3;
	localparam int CFG_W   = 32;
	localparam int CFG_IDX_W = 2;

	localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [7:0] SEP_BYTE   = 8'h5C;
	localparam logic [7:0] DOT_BYTE   = 8'h2E;
	localparam logic [7:0] SLASH_BYTE = 8'h2F;
	localparam logic [7:0] UPPER_A    = 8'h41;
	localparam logic [7:0] UPPER_Z    = 8'h5A;
	localparam logic [7:0] CASE_OFFS  = 8'h20;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_FOLDER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_FILE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_EXT    = 2'd2;

	// Class of a normalised path character.
	typedef enum logic [1:0] {
		CLS_OTHER = 2'd0,
		CLS_SEP   = 2'd1,
		CLS_DOT   = 2'd2
	} chr_class_t;

	// One classified item as it travels through the queue.
	typedef struct packed {
		logic [7:0]  ch;
		chr_class_t  cls;
		logic        last;
	} pctm_item_t;

	// Lowercases A-Z and maps a forward slash onto a backslash.
	function automatic logic [7:0] normalise(input logic [7:0] b);
		logic [7:0] c;
		c = (b == SLASH_BYTE) ? SEP_BYTE : b;
		if (c >= UPPER_A && c <= UPPER_Z) begin
			c = c + CASE_OFFS;
		end
		return c;
	endfunction

	// One byte of the reflected CRC-32, unrolled into an XOR network.
	function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
			input logic [7:0] b);
		logic [CRC_W-1:0] r;
		r = crc ^ {{(CRC_W-8){1'b0}}, b};
		for (int k = 0; k < 8; k++) begin
			r = (r >> 1) ^ (CRC_POLY & {CRC_W{r[0]}});
		end
		return r;
	endfunction

endpackage

/* src/path_crc_triple_matcher_unit.sv */
// The final character of a path is registered in the front end and held in
// the queue; its result is then registered onto out_valid. Throughput: one
// character per cycle unless in_stall is high, set by the single-byte CRC update
// in the back end; one result per path, taken while the next path streams in.
// Reset: arst_n clears the target registers, path trackers, ordinal and queue.
module path_crc_triple_matcher_unit import pctm_pkg::*; #(
	parameter int EXT_BYTES   = DEF_EXT_BYTES,
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           char_byte,
	input  logic                 end_of_path,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [CRC_W-1:0]     folder_crc,
	output logic [CRC_W-1:0]     file_crc,
	output logic [CRC_W-1:0]     ext_word,
	output logic                 is_match,
	output logic [ORD_W-1:0]     path_ordinal
);

	logic       push, queue_full, pop, head_valid;
	pctm_item_t push_item, head_item;

	// Front end: register and classify each character.
	pctm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.char_byte  (char_byte),
		.end_of_path(end_of_path),
		.push       (push),
		.push_item  (push_item),
		.queue_full (queue_full)
	);

	// Short queue between the two halves.
	pctm_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (queue_full),
		.pop       (pop),
		.head_valid(head_valid),
		.head_item (head_item)
	);

	// Back end: CRC tracking, result register and target compare.
	pctm_back #(
		.EXT_BYTES(EXT_BYTES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_item   (head_item),
		.pop         (pop),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.folder_crc  (folder_crc),
		.file_crc    (file_crc),
		.ext_word    (ext_word),
		.is_match    (is_match),
		.path_ordinal(path_ordinal)
	);

endmodule

/* src/pctm_front.sv */
module pctm_front import pctm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_byte,
	input  logic       end_of_path,
	output logic       push,
	output pctm_item_t push_item,
	input  logic       queue_full
);

	logic       valid_s1;
	pctm_item_t item_s1;
	logic       accept;
	logic [7:0] norm;
	chr_class_t cls;

	// Normalise and classify the incoming character.
	always_comb begin
		norm = normalise(char_byte);
		if (norm == SEP_BYTE) begin
			cls = CLS_SEP;
		end else if (norm == DOT_BYTE) begin
			cls = CLS_DOT;
		end else begin
			cls = CLS_OTHER;
		end
	end

	// The stage holds an item until the queue takes it.
	assign push      = valid_s1 && !queue_full;
	assign in_stall  = valid_s1 && queue_full;
	assign accept    = in_valid && !in_stall;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= '{ch: norm, cls: cls, last: end_of_path};
		end
	end

endmodule

/* src/pctm_queue.sv */
module pctm_queue import pctm_pkg::*; #(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  pctm_item_t push_item,
	output logic       full,
	input  logic       pop,
	output logic       head_valid,
	output pctm_item_t head_item
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_QW-1:0] DEPTH_CNT = CNT_QW'(QUEUE_DEPTH);

	pctm_item_t        slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_QW-1:0] count_q;

	assign full       = (count_q == DEPTH_CNT);
	assign head_valid = (count_q != '0);
	assign head_item  = slot_q[rd_ptr_q];

	// Pointers wrap at the last slot, whatever the depth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

/* src/pctm_back.sv */
module pctm_back import pctm_pkg::*; #(
	parameter int EXT_BYTES = DEF_EXT_BYTES
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head_valid,
	input  pctm_item_t           head_item,
	output logic                 pop,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [CRC_W-1:0]     folder_crc,
	output logic [CRC_W-1:0]     file_crc,
	output logic [CRC_W-1:0]     ext_word,
	output logic                 is_match,
	output logic [ORD_W-1:0]     path_ordinal
);

	localparam logic [CNT_W-1:0] EXT_MAX = CNT_W'(EXT_BYTES);

	// Target registers.
	logic [CRC_W-1:0] tgt_folder_q, tgt_file_q, tgt_ext_q;

	// Per-path state.
	logic [CRC_W-1:0] whole_q, folder_snap_q, comp_q, stem_snap_q, ext_q;
	logic [CNT_W-1:0] ext_cnt_q;
	logic             seen_sep_q, seen_dot_q;
	logic [ORD_W-1:0] path_cnt_q;

	logic [CRC_W-1:0] whole_n, folder_snap_n, comp_n, stem_snap_n, ext_n;
	logic [CNT_W-1:0] ext_cnt_n;
	logic             seen_sep_n, seen_dot_n;
	logic [CRC_W-1:0] res_folder, res_file, res_ext;

	// Output register.
	logic             out_valid_q;
	logic [CRC_W-1:0] folder_q, file_q, ext_out_q;
	logic [ORD_W-1:0] ord_q;

	logic out_free;
	logic finish;

	assign out_free = !out_valid_q || !out_stall;
	assign pop      = head_valid && (!head_item.last || out_free);
	assign finish   = pop && head_item.last;

	// Configuration writes; an unknown index is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_folder_q <= '0;
			tgt_file_q   <= '0;
			tgt_ext_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TARGET_FOLDER: tgt_folder_q <= cfg_data;
				REG_TARGET_FILE:   tgt_file_q   <= cfg_data;
				REG_TARGET_EXT:    tgt_ext_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Next state of the path trackers for the item at the head of the queue.
	always_comb begin
		whole_n       = crc_byte(whole_q, head_item.ch);
		folder_snap_n = folder_snap_q;
		comp_n        = comp_q;
		stem_snap_n   = stem_snap_q;
		ext_n         = ext_q;
		ext_cnt_n     = ext_cnt_q;
		seen_sep_n    = seen_sep_q;
		seen_dot_n    = seen_dot_q;
		case (head_item.cls)
			CLS_SEP: begin
				folder_snap_n = whole_q;
				seen_sep_n    = 1'b1;
				comp_n        = '0;
				stem_snap_n   = '0;
				seen_dot_n    = 1'b0;
				ext_n         = '0;
				ext_cnt_n     = '0;
			end
			CLS_DOT: begin
				stem_snap_n = comp_q;
				seen_dot_n  = 1'b1;
				ext_n       = '0;
				ext_cnt_n   = '0;
				comp_n      = crc_byte(comp_q, head_item.ch);
			end
			default: begin
				if (seen_dot_q && ext_cnt_q < EXT_MAX) begin
					ext_n[8*ext_cnt_q[1:0] +: 8] = head_item.ch;
					ext_cnt_n = ext_cnt_q + 1'b1;
				end
				comp_n = crc_byte(comp_q, head_item.ch);
			end
		endcase
		res_folder = seen_sep_n ? folder_snap_n : '0;
		res_file   = seen_dot_n ? stem_snap_n : comp_n;
		res_ext    = seen_dot_n ? ext_n : '0;
	end

	// State update; the per-path part clears when a path's final character is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			whole_q       <= '0;
			folder_snap_q <= '0;
			comp_q        <= '0;
			stem_snap_q   <= '0;
			ext_q         <= '0;
			ext_cnt_q     <= '0;
			seen_sep_q    <= 1'b0;
			seen_dot_q    <= 1'b0;
			path_cnt_q    <= '0;
		end else if (finish) begin
			whole_q       <= '0;
			folder_snap_q <= '0;
			comp_q        <= '0;
			stem_snap_q   <= '0;
			ext_q         <= '0;
			ext_cnt_q     <= '0;
			seen_sep_q    <= 1'b0;
			seen_dot_q    <= 1'b0;
			path_cnt_q    <= path_cnt_q + 1'b1;
		end else if (pop) begin
			whole_q       <= whole_n;
			folder_snap_q <= folder_snap_n;
			comp_q        <= comp_n;
			stem_snap_q   <= stem_snap_n;
			ext_q         <= ext_n;
			ext_cnt_q     <= ext_cnt_n;
			seen_sep_q    <= seen_sep_n;
			seen_dot_q    <= seen_dot_n;
		end
	end

	// Result register towards the output channel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			folder_q  <= res_folder;
			file_q    <= res_file;
			ext_out_q <= res_ext;
			ord_q     <= path_cnt_q;
		end
	end

	// The user must change the targets only while no result is pending (not
	// enforced here), so the compare can follow the result register directly.
	assign is_match     = (folder_q == tgt_folder_q) && (file_q == tgt_file_q) &&
			(ext_out_q == tgt_ext_q);
	assign out_valid    = out_valid_q;
	assign folder_crc   = folder_q;
	assign file_crc     = file_q;
	assign ext_word     = ext_out_q;
	assign path_ordinal = ord_q;

endmodule

/* src/pctm_checker.sv */
module pctm_checker import pctm_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic                 end_of_path,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic [CRC_W-1:0]     folder_crc,
	input logic [CRC_W-1:0]     file_crc,
	input logic [CRC_W-1:0]     ext_word,
	input logic                 is_match,
	input logic [ORD_W-1:0]     path_ordinal
);

	logic             in_end, out_take;
	logic [3:0]       pending_q;
	logic [ORD_W-1:0] next_ord_q;

	assign in_end   = in_valid && !in_stall && end_of_path;
	assign out_take = out_valid && !out_stall;

	// Paths accepted whose result has not yet been taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_end && !out_take) begin
			pending_q <= pending_q + 1'b1;
		end else if (out_take && !in_end) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	// Ordinal expected on the next result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_ord_q <= '0;
		end else if (out_take) begin
			next_ord_q <= path_ordinal + 1'b1;
		end
	end

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(folder_crc) && $stable(file_crc) &&
			$stable(ext_word) && $stable(is_match) && $stable(path_ordinal))
		else $error("result payload changed while stalled");

	// No result appears without a completed path behind it.
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != '0)
		else $error("result without a completed path");

	// Results carry consecutive ordinals.
	a_ordinal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> path_ordinal == next_ord_q)
		else $error("path ordinal out of sequence");

endmodule

bind path_crc_triple_matcher_unit pctm_checker u_pctm_checker (.*);
